@@ sv/dbcf_pkg.sv @@
// ----------------------------------------------------------------------------
// dbcf_pkg
// Shared types and constants of the per-bank DRAM command state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package dbcf_pkg;

  localparam int unsigned ROW_BITS  = 17;
  localparam int unsigned CNT_BITS  = 16;
  localparam int unsigned ADDR_BITS = 4;

  // register byte addresses
  localparam logic [ADDR_BITS-1:0] ADDR_PAGE_POLICY  = 4'h0;
  localparam logic [ADDR_BITS-1:0] ADDR_RFM_ON       = 4'h4;
  localparam logic [ADDR_BITS-1:0] ADDR_RAA_DEC      = 4'h8;
  localparam logic [ADDR_BITS-1:0] ADDR_RAA_RFM_DEC  = 4'hC;

  typedef enum logic [1:0] {
    POLICY_OPEN           = 2'd0,
    POLICY_CLOSED         = 2'd1,
    POLICY_OPEN_ADAPTIVE  = 2'd2,
    POLICY_CLOSED_ADAPTIVE = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    MODE_EVAL   = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_BLOCK  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    CLS_OTHER   = 4'd0,
    CLS_ACT     = 4'd1,
    CLS_PRE     = 4'd2,
    CLS_RDWR    = 4'd3,
    CLS_RDWR_AP = 4'd4,
    CLS_PD_SR   = 4'd5,
    CLS_REF     = 4'd6,
    CLS_RFM     = 4'd7,
    CLS_PD_EXIT = 4'd8
  } cls_e;

  typedef enum logic [3:0] {
    CMD_NOP  = 4'd0,
    CMD_ACT  = 4'd1,
    CMD_PRE  = 4'd2,
    CMD_RD   = 4'd3,
    CMD_WR   = 4'd4,
    CMD_MWR  = 4'd5,
    CMD_RDA  = 4'd6,
    CMD_WRA  = 4'd7,
    CMD_MWRA = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [1:0]          policy;
    logic                rfm_on;
    logic [CNT_BITS-1:0] raa_dec;
    logic [CNT_BITS-1:0] raa_rfm_dec;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic                request_valid;
    logic [ROW_BITS-1:0] request_row;
    logic                request_is_read;
    logic                request_masked;
    logic                further_request;
    logic                further_row_hit;
    logic [3:0]          issued_class;
  } item_t;

  typedef struct packed {
    logic [3:0]          next_command;
    logic                took_request;
    logic                bank_idle;
    logic                bank_activated;
    logic [ROW_BITS-1:0] open_row_out;
    logic [CNT_BITS-1:0] activation_count;
  } res_t;

endpackage

`default_nettype wire

@@ sv/dbcf_if.sv @@
// ----------------------------------------------------------------------------
// dbcf_in_if / dbcf_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbcf_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic                          request_valid;
  logic [dbcf_pkg::ROW_BITS-1:0] request_row;
  logic                          request_is_read;
  logic                          request_masked;
  logic                          further_request;
  logic                          further_row_hit;
  logic [3:0]                    issued_class;

  modport source (
    output valid, mode, request_valid, request_row, request_is_read,
           request_masked, further_request, further_row_hit, issued_class,
    input  ready
  );
  modport sink (
    input  valid, mode, request_valid, request_row, request_is_read,
           request_masked, further_request, further_row_hit, issued_class,
    output ready
  );
endinterface

interface dbcf_out_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    next_command;
  logic                          took_request;
  logic                          bank_idle;
  logic                          bank_activated;
  logic [dbcf_pkg::ROW_BITS-1:0] open_row_out;
  logic [dbcf_pkg::CNT_BITS-1:0] activation_count;

  modport source (
    output valid, next_command, took_request, bank_idle, bank_activated,
           open_row_out, activation_count,
    input  ready
  );
  modport sink (
    input  valid, next_command, took_request, bank_idle, bank_activated,
           open_row_out, activation_count,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/dram_bank_command_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// dram_bank_command_fsm_unit
// Per-bank DRAM command state machine with selectable page policy.
//
// Usage: each word on in_i is an evaluate, update or block event for the
// bank; each produces exactly one result word on out_o carrying the chosen
// command, the take flag and the bank's state after the event. Registers
// are to be written over the APB port only while no event is in flight;
// the block itself does not enforce this. Pipeline: a word is held in the
// input register, and the state update and result are computed from it
// and land in the output register.
// Throughput: one word per cycle while out_o.ready is high; the state
// feedback loop through the core's next-state logic is not pipelined.
// Reset: all bank state clears (precharged, idle, counter zero, NOP) and
// the registers return to open page policy with refresh management off.
// Stall: when out_o.ready is low the output register holds its word, the
// input register holds one more, and in_i.ready drops until the result
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dram_bank_command_fsm_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  dbcf_in_if.sink                        in_i,
  dbcf_out_if.source                     out_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [dbcf_pkg::ADDR_BITS-1:0] paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dbcf_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  res_t  res, res_q;
  logic  out_vld_q;
  logic  adv;
  logic  in_acc;

  dbcf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // advance the held word into the output register when it has room
  assign adv       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_acc    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.mode            <= in_i.mode;
      item_q.request_valid   <= in_i.request_valid;
      item_q.request_row     <= in_i.request_row;
      item_q.request_is_read <= in_i.request_is_read;
      item_q.request_masked  <= in_i.request_masked;
      item_q.further_request <= in_i.further_request;
      item_q.further_row_hit <= in_i.further_row_hit;
      item_q.issued_class    <= in_i.issued_class;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  dbcf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_o.valid            = out_vld_q;
  assign out_o.next_command     = res_q.next_command;
  assign out_o.took_request     = res_q.took_request;
  assign out_o.bank_idle        = res_q.bank_idle;
  assign out_o.bank_activated   = res_q.bank_activated;
  assign out_o.open_row_out     = res_q.open_row_out;
  assign out_o.activation_count = res_q.activation_count;

endmodule

`default_nettype wire

@@ sv/dbcf_cfg.sv @@
// ----------------------------------------------------------------------------
// dbcf_cfg
// APB register file: page policy, refresh management enable and the two
// activation counter decrement amounts.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcf_cfg (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [dbcf_pkg::ADDR_BITS-1:0] paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output dbcf_pkg::cfg_t                 cfg_o
);
  import dbcf_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr)
        ADDR_PAGE_POLICY: cfg_q.policy      <= pwdata[1:0];
        ADDR_RFM_ON:      cfg_q.rfm_on      <= pwdata[0];
        ADDR_RAA_DEC:     cfg_q.raa_dec     <= pwdata[CNT_BITS-1:0];
        ADDR_RAA_RFM_DEC: cfg_q.raa_rfm_dec <= pwdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_PAGE_POLICY: prdata = {30'd0, cfg_q.policy};
      ADDR_RFM_ON:      prdata = {31'd0, cfg_q.rfm_on};
      ADDR_RAA_DEC:     prdata = {{(32-CNT_BITS){1'b0}}, cfg_q.raa_dec};
      ADDR_RAA_RFM_DEC: prdata = {{(32-CNT_BITS){1'b0}}, cfg_q.raa_rfm_dec};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/dbcf_core.sv @@
// ----------------------------------------------------------------------------
// dbcf_core
// Bank state registers and the single-pass next-state and command logic.
// State advances by one word whenever adv_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcf_core (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             adv_i,
  input  dbcf_pkg::item_t item_i,
  input  dbcf_pkg::cfg_t  cfg_i,
  output dbcf_pkg::res_t  res_o
);
  import dbcf_pkg::*;

  logic                activated_q, activated_d;
  logic [ROW_BITS-1:0] open_row_q, open_row_d;
  logic                holding_q, holding_d;
  logic [ROW_BITS-1:0] held_row_q, held_row_d;
  logic                held_read_q, held_read_d;
  logic                held_masked_q, held_masked_d;
  logic                keep_q, keep_d;
  logic                asleep_q, asleep_d;
  logic                blocked_q, blocked_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [3:0]          pend_q, pend_d;

  logic                took;
  logic                auto_pre;
  logic [CNT_BITS-1:0] dec;
  logic [3:0]          acc_cmd;

  always_comb begin
    case (cfg_i.policy)
      POLICY_OPEN:          auto_pre = 1'b0;
      POLICY_CLOSED:        auto_pre = 1'b1;
      POLICY_OPEN_ADAPTIVE: auto_pre = item_i.further_request && !item_i.further_row_hit;
      default:              auto_pre = !item_i.further_row_hit;
    endcase
  end

  // access command from the held request after this word's take
  always_comb begin
    if (held_read_d) begin
      acc_cmd = auto_pre ? CMD_RDA : CMD_RD;
    end else if (held_masked_d) begin
      acc_cmd = auto_pre ? CMD_MWRA : CMD_MWR;
    end else begin
      acc_cmd = auto_pre ? CMD_WRA : CMD_WR;
    end
  end

  always_comb begin
    dec = (item_i.issued_class == CLS_REF) ? cfg_i.raa_dec : cfg_i.raa_rfm_dec;
  end

  always_comb begin
    activated_d   = activated_q;
    open_row_d    = open_row_q;
    holding_d     = holding_q;
    held_row_d    = held_row_q;
    held_read_d   = held_read_q;
    held_masked_d = held_masked_q;
    keep_d        = keep_q;
    asleep_d      = asleep_q;
    blocked_d     = blocked_q;
    cnt_d         = cnt_q;
    pend_d        = pend_q;
    took          = 1'b0;

    case (item_i.mode)
      MODE_EVAL: begin
        pend_d = CMD_NOP;
        if (!asleep_q && !blocked_q && item_i.request_valid) begin
          if (!keep_q || item_i.request_row == open_row_q) begin
            took          = 1'b1;
            holding_d     = 1'b1;
            held_row_d    = item_i.request_row;
            held_read_d   = item_i.request_is_read;
            held_masked_d = item_i.request_masked;
          end
          if (!activated_q) begin
            pend_d = CMD_ACT;
          end else if (cfg_i.policy != POLICY_CLOSED && held_row_d != open_row_q) begin
            pend_d = CMD_PRE;
          end else begin
            pend_d = acc_cmd;
          end
        end
      end
      MODE_UPDATE: begin
        case (item_i.issued_class)
          CLS_ACT: begin
            activated_d = 1'b1;
            open_row_d  = held_row_q;
            keep_d      = 1'b1;
            if (cnt_q != '1) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          CLS_PRE: begin
            activated_d = 1'b0;
            keep_d      = 1'b0;
          end
          CLS_RDWR: begin
            holding_d = 1'b0;
            keep_d    = 1'b0;
          end
          CLS_RDWR_AP: begin
            activated_d = 1'b0;
            holding_d   = 1'b0;
            keep_d      = 1'b0;
          end
          CLS_PD_SR: asleep_d = 1'b1;
          CLS_REF, CLS_RFM: begin
            asleep_d  = 1'b0;
            blocked_d = 1'b0;
            if (cfg_i.rfm_on) begin
              cnt_d = (cnt_q > dec) ? cnt_q - dec : '0;
            end
          end
          CLS_PD_EXIT: asleep_d = 1'b0;
          default: ;
        endcase
      end
      MODE_BLOCK: begin
        blocked_d = 1'b1;
        pend_d    = CMD_NOP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      activated_q   <= 1'b0;
      open_row_q    <= '0;
      holding_q     <= 1'b0;
      held_row_q    <= '0;
      held_read_q   <= 1'b0;
      held_masked_q <= 1'b0;
      keep_q        <= 1'b0;
      asleep_q      <= 1'b0;
      blocked_q     <= 1'b0;
      cnt_q         <= '0;
      pend_q        <= CMD_NOP;
    end else if (adv_i) begin
      activated_q   <= activated_d;
      open_row_q    <= open_row_d;
      holding_q     <= holding_d;
      held_row_q    <= held_row_d;
      held_read_q   <= held_read_d;
      held_masked_q <= held_masked_d;
      keep_q        <= keep_d;
      asleep_q      <= asleep_d;
      blocked_q     <= blocked_d;
      cnt_q         <= cnt_d;
      pend_q        <= pend_d;
    end
  end

  assign res_o.next_command     = pend_d;
  assign res_o.took_request     = took;
  assign res_o.bank_idle        = !holding_d;
  assign res_o.bank_activated   = activated_d;
  assign res_o.open_row_out     = open_row_d;
  assign res_o.activation_count = cnt_d;

endmodule

`default_nettype wire

@@ bench/dram_bank_command_fsm_unit_tb.sv @@
// ----------------------------------------------------------------------------
// dram_bank_command_fsm_unit_tb
// Self-checking bench for the per-bank DRAM command state machine. A queue of
// bank events (evaluate, update, block) feeds a bursty valid/ready driver.
// Each accepted word is run through a behavioral copy of the bank, and the
// result words are checked field by field against it. The page policy and
// refresh management registers are changed between phases over APB.
// ----------------------------------------------------------------------------
module dram_bank_command_fsm_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbcf_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned MAX_REPORTS = 30;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dbcf_in_if  in_if ();
  dbcf_out_if out_if ();

  dram_bank_command_fsm_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bank model state and its register copies
  policy_e             cfg_policy = POLICY_OPEN;
  logic                cfg_rfm_on = 1'b0;
  logic [CNT_BITS-1:0] cfg_ref_dec = '0;
  logic [CNT_BITS-1:0] cfg_rfm_dec = '0;

  logic                bank_open = 1'b0;
  logic [ROW_BITS-1:0] bank_open_row = '0;
  logic                bank_holding = 1'b0;
  logic [ROW_BITS-1:0] bank_held_row = '0;
  logic                bank_held_read = 1'b0;
  logic                bank_held_masked = 1'b0;
  logic                bank_keep_txn = 1'b0;
  logic                bank_asleep = 1'b0;
  logic                bank_blocked = 1'b0;
  logic [CNT_BITS-1:0] bank_act_cnt = '0;
  cmd_e                bank_cmd = CMD_NOP;

  item_t bank_event_q[$];
  res_t  bank_resp_q[$];
  logic [ROW_BITS-1:0] row_pool[4];

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  logic long_hold_go = 1'b0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned pat_left = 0;
  int unsigned pat_kind = 0;
  int unsigned hold_left = 0;
  logic hold_used = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one bank event to the model and return the word it must produce.
  task automatic step_bank(input item_t ev, output res_t resp);
    logic took;
    logic auto_pre;
    took = 1'b0;
    auto_pre = 1'b0;
    case (ev.mode)
      MODE_EVAL: begin
        bank_cmd = CMD_NOP;
        if (!bank_asleep && !bank_blocked && ev.request_valid) begin
          // a kept transaction only accepts hits to its open row
          if (!bank_keep_txn || ev.request_row == bank_open_row) begin
            bank_holding = 1'b1;
            bank_held_row = ev.request_row;
            bank_held_read = ev.request_is_read;
            bank_held_masked = ev.request_masked;
            took = 1'b1;
          end
          if (!bank_open) begin
            bank_cmd = CMD_ACT;
          end else if (cfg_policy != POLICY_CLOSED && bank_held_row != bank_open_row) begin
            bank_cmd = CMD_PRE;
          end else begin
            case (cfg_policy)
              POLICY_OPEN:          auto_pre = 1'b0;
              POLICY_CLOSED:        auto_pre = 1'b1;
              POLICY_OPEN_ADAPTIVE: auto_pre = ev.further_request && !ev.further_row_hit;
              default:              auto_pre = !ev.further_row_hit;
            endcase
            if (bank_held_read) begin
              bank_cmd = auto_pre ? CMD_RDA : CMD_RD;
            end else if (bank_held_masked) begin
              bank_cmd = auto_pre ? CMD_MWRA : CMD_MWR;
            end else begin
              bank_cmd = auto_pre ? CMD_WRA : CMD_WR;
            end
          end
        end
      end
      MODE_UPDATE: begin
        case (ev.issued_class)
          CLS_ACT: begin
            bank_open = 1'b1;
            bank_open_row = bank_held_row;
            bank_keep_txn = 1'b1;
            if (bank_act_cnt != '1) bank_act_cnt = bank_act_cnt + 1'b1;
          end
          CLS_PRE: begin
            bank_open = 1'b0;
            bank_keep_txn = 1'b0;
          end
          CLS_RDWR: begin
            bank_holding = 1'b0;
            bank_keep_txn = 1'b0;
          end
          CLS_RDWR_AP: begin
            bank_open = 1'b0;
            bank_holding = 1'b0;
            bank_keep_txn = 1'b0;
          end
          CLS_PD_SR: bank_asleep = 1'b1;
          CLS_REF: begin
            bank_asleep = 1'b0;
            bank_blocked = 1'b0;
            if (cfg_rfm_on) begin
              bank_act_cnt = (bank_act_cnt > cfg_ref_dec) ? bank_act_cnt - cfg_ref_dec : '0;
            end
          end
          CLS_RFM: begin
            bank_asleep = 1'b0;
            bank_blocked = 1'b0;
            if (cfg_rfm_on) begin
              bank_act_cnt = (bank_act_cnt > cfg_rfm_dec) ? bank_act_cnt - cfg_rfm_dec : '0;
            end
          end
          CLS_PD_EXIT: bank_asleep = 1'b0;
          default: ;
        endcase
      end
      MODE_BLOCK: begin
        bank_blocked = 1'b1;
        bank_cmd = CMD_NOP;
      end
      default: ;
    endcase
    resp.next_command = bank_cmd;
    resp.took_request = took;
    resp.bank_idle = !bank_holding;
    resp.bank_activated = bank_open;
    resp.open_row_out = bank_open_row;
    resp.activation_count = bank_act_cnt;
  endtask

  // Driver: hold the current word until taken, then pace in bursts and gaps.
  always @(posedge clk_i) begin
    logic taken;
    logic offer;
    res_t resp;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      taken = in_if.valid && in_if.ready;
      if (taken) begin
        step_bank(bank_event_q[0], resp);
        bank_resp_q.push_back(resp);
        void'(bank_event_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (in_if.valid && !taken) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        offer = 1'b0;
      end else begin
        offer = bank_event_q.size() > 0;
      end
      in_if.valid <= offer;
      if (offer) begin
        in_if.mode <= bank_event_q[0].mode;
        in_if.request_valid <= bank_event_q[0].request_valid;
        in_if.request_row <= bank_event_q[0].request_row;
        in_if.request_is_read <= bank_event_q[0].request_is_read;
        in_if.request_masked <= bank_event_q[0].request_masked;
        in_if.further_request <= bank_event_q[0].further_request;
        in_if.further_row_hit <= bank_event_q[0].further_row_hit;
        in_if.issued_class <= bank_event_q[0].issued_class;
      end
    end
  end

  // Receiver: stall on a changing pattern, with one long hold-off on request.
  always @(posedge clk_i) begin
    logic take;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (long_hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(5, 60);
        end
        pat_left--;
        case (pat_kind)
          0:       take = 1'b1;
          1:       take = 1'($urandom_range(0, 1));
          2:       take = ($urandom_range(0, 3) == 0);
          default: take = pat_left[0];
        endcase
      end
      out_if.ready <= take;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      end
    end
  endtask

  // Monitor: compare every accepted word against the oldest model response.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (bank_resp_q.size() == 0) begin
        fail_count++;
        $display("%0t: result word with none outstanding, expected none, actual cmd %0h",
                 $time, out_if.next_command);
      end else begin
        want = bank_resp_q.pop_front();
        check_field("next_command", 32'(want.next_command), 32'(out_if.next_command));
        check_field("took_request", 32'(want.took_request), 32'(out_if.took_request));
        check_field("bank_idle", 32'(want.bank_idle), 32'(out_if.bank_idle));
        check_field("bank_activated", 32'(want.bank_activated),
                    32'(out_if.bank_activated));
        check_field("open_row_out", 32'(want.open_row_out), 32'(out_if.open_row_out));
        check_field("activation_count", 32'(want.activation_count),
                    32'(out_if.activation_count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
    logic [31:0] mask;
    case (addr)
      ADDR_PAGE_POLICY: mask = 32'h3;
      ADDR_RFM_ON:      mask = 32'h1;
      default:          mask = 32'hFFFF;
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // write lands here; turn straight into a read-back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (data & mask)) begin
      fail_count++;
      $display("%0t: register %0h read-back, expected %0h, actual %0h",
               $time, addr, data & mask, prdata & mask);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input policy_e pol, input logic rfm_on,
                            input logic [CNT_BITS-1:0] ref_dec,
                            input logic [CNT_BITS-1:0] rfm_dec);
    write_reg(ADDR_PAGE_POLICY, 32'(pol));
    write_reg(ADDR_RFM_ON, 32'(rfm_on));
    write_reg(ADDR_RAA_DEC, 32'(ref_dec));
    write_reg(ADDR_RAA_RFM_DEC, 32'(rfm_dec));
    cfg_policy = pol;
    cfg_rfm_on = rfm_on;
    cfg_ref_dec = ref_dec;
    cfg_rfm_dec = rfm_dec;
  endtask

  function automatic item_t noise_item();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t eval_item(input logic [ROW_BITS-1:0] row, input logic rd,
                                      input logic mk, input logic freq, input logic fhit);
    item_t ev;
    ev = noise_item();
    ev.mode = MODE_EVAL;
    ev.request_valid = 1'b1;
    ev.request_row = row;
    ev.request_is_read = rd;
    ev.request_masked = mk;
    ev.further_request = freq;
    ev.further_row_hit = fhit;
    return ev;
  endfunction

  function automatic item_t rand_eval(input logic [ROW_BITS-1:0] row);
    return eval_item(row, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic item_t update_item(input logic [3:0] cls);
    item_t ev;
    ev = noise_item();
    ev.mode = MODE_UPDATE;
    ev.issued_class = cls;
    return ev;
  endfunction

  function automatic item_t mode_item(input logic [1:0] mode);
    item_t ev;
    ev = noise_item();
    ev.mode = mode;
    return ev;
  endfunction

  function automatic logic [3:0] pick_class();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return CLS_OTHER;
    if (sel < 20) return CLS_ACT;
    if (sel < 35) return CLS_PRE;
    if (sel < 50) return CLS_RDWR;
    if (sel < 62) return CLS_RDWR_AP;
    if (sel < 70) return CLS_PD_SR;
    if (sel < 80) return CLS_REF;
    if (sel < 90) return CLS_RFM;
    if (sel < 96) return CLS_PD_EXIT;
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic logic [ROW_BITS-1:0] pick_row();
    if ($urandom_range(0, 4) == 0) return ROW_BITS'($urandom);
    return row_pool[$urandom_range(0, 3)];
  endfunction

  task automatic fill_row_pool();
    foreach (row_pool[k]) row_pool[k] = ROW_BITS'($urandom);
    if ($urandom_range(0, 1) == 0) row_pool[0] = '0;
    if ($urandom_range(0, 1) == 0) row_pool[1] = '1;
  endtask

  // Mostly scheduler-like sequences over a small row set, with noise mixed in.
  task automatic queue_traffic(input int unsigned n_items);
    int unsigned added;
    int unsigned sel;
    logic [ROW_BITS-1:0] row;
    added = 0;
    fill_row_pool();
    while (added < n_items) begin
      sel = $urandom_range(0, 99);
      row = pick_row();
      if (sel < 35) begin
        bank_event_q.push_back(rand_eval(row));
        bank_event_q.push_back(update_item(CLS_ACT));
        bank_event_q.push_back(rand_eval(row));
        bank_event_q.push_back(update_item($urandom_range(0, 1) ? CLS_RDWR : CLS_RDWR_AP));
        added += 4;
      end else if (sel < 50) begin
        bank_event_q.push_back(rand_eval(row));
        bank_event_q.push_back(update_item(CLS_PRE));
        bank_event_q.push_back(update_item(CLS_ACT));
        bank_event_q.push_back(rand_eval(row));
        added += 4;
      end else if (sel < 80) begin
        bank_event_q.push_back(update_item(pick_class()));
        added += 1;
      end else if (sel < 90) begin
        bank_event_q.push_back(rand_eval(row));
        added += 1;
      end else if (sel < 94) begin
        bank_event_q.push_back(mode_item(MODE_BLOCK));
        added += 1;
      end else if (sel < 96) begin
        bank_event_q.push_back(mode_item(MODE_EVAL));
        added += 1;
      end else if (sel < 97) begin
        bank_event_q.push_back(mode_item(MODE_UNUSED));
        added += 1;
      end else begin
        bank_event_q.push_back(update_item(CLS_PD_SR));
        bank_event_q.push_back(rand_eval(row));
        case ($urandom_range(0, 2))
          0:       bank_event_q.push_back(update_item(CLS_PD_EXIT));
          1:       bank_event_q.push_back(update_item(CLS_REF));
          default: bank_event_q.push_back(update_item(CLS_RFM));
        endcase
        added += 3;
      end
    end
  endtask

  // Wait until every word is sent and answered, plus the pipeline depth.
  task automatic drain();
    do @(negedge clk_i);
    while (bank_event_q.size() != 0 || bank_resp_q.size() != 0 || in_if.valid);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_directed();
    item_t ev;
    ev = eval_item('1, 1'b1, 1'b1, 1'b1, 1'b1);
    ev.request_valid = 1'b0;
    bank_event_q.push_back(ev);                                     // nothing offered
    ev = '1;
    ev.mode = MODE_UNUSED;
    bank_event_q.push_back(ev);                                     // unused mode
    bank_event_q.push_back(update_item(CLS_ACT));                   // activate, nothing held
    bank_event_q.push_back(eval_item('1, 1'b1, 1'b0, 1'b0, 1'b0));  // kept row, stale fields
    bank_event_q.push_back(eval_item('0, 1'b1, 1'b1, 1'b0, 1'b0));  // hit, taken
    bank_event_q.push_back(update_item(CLS_RDWR));
    bank_event_q.push_back(eval_item('1, 1'b0, 1'b1, 1'b1, 1'b0));  // row miss
    bank_event_q.push_back(update_item(CLS_PRE));
    bank_event_q.push_back(eval_item('1, 1'b0, 1'b1, 1'b0, 1'b1));  // precharged
    bank_event_q.push_back(update_item(CLS_ACT));
    bank_event_q.push_back(eval_item('1, 1'b0, 1'b1, 1'b1, 1'b1));  // masked write hit
    bank_event_q.push_back(update_item(CLS_PD_SR));
    bank_event_q.push_back(eval_item('1, 1'b1, 1'b0, 1'b0, 1'b0));  // asleep
    bank_event_q.push_back(update_item(CLS_PD_EXIT));
    bank_event_q.push_back(mode_item(MODE_BLOCK));
    bank_event_q.push_back(eval_item('1, 1'b1, 1'b0, 1'b0, 1'b0));  // blocked
    bank_event_q.push_back(update_item(CLS_REF));
    bank_event_q.push_back(update_item(CLS_RFM));                   // floors at zero
    bank_event_q.push_back(update_item(4'hF));
    bank_event_q.push_back(update_item(CLS_OTHER));
    bank_event_q.push_back(update_item(CLS_RDWR_AP));
    bank_event_q.push_back(eval_item('0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_EVAL;
    in_if.request_valid = 1'b0;
    in_if.request_row = '0;
    in_if.request_is_read = 1'b0;
    in_if.request_masked = 1'b0;
    in_if.further_request = 1'b0;
    in_if.further_row_hit = 1'b0;
    in_if.issued_class = CLS_OTHER;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    set_config(POLICY_OPEN, 1'b1, 16'd1, 16'd2);
    queue_directed();
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(POLICY_OPEN, 1'b1, 16'd3, 16'd5);
        1: set_config(POLICY_CLOSED, 1'b0, 16'hFFFF, 16'hFFFF);
        2: set_config(POLICY_OPEN_ADAPTIVE, 1'b1, 16'd0, 16'd0);
        3: set_config(POLICY_CLOSED_ADAPTIVE, 1'b1, 16'hFFFF, 16'd1);
        4: set_config(POLICY_OPEN, 1'b1, 16'($urandom_range(1, 20)),
                      16'($urandom_range(1, 20)));
        5: set_config(POLICY_CLOSED_ADAPTIVE, 1'b0, 16'($urandom), 16'($urandom));
        6: set_config(POLICY_OPEN_ADAPTIVE, 1'b1, 16'($urandom_range(1, 8)),
                      16'($urandom));
        default: set_config(POLICY_CLOSED, 1'b1, 16'($urandom), 16'($urandom_range(1, 8)));
      endcase
      @(negedge clk_i);
      // stall the result side for a long stretch while words keep coming
      if (p == 1) long_hold_go = 1'b1;
      queue_traffic(230);
      drain();
    end

    set_config(POLICY_CLOSED_ADAPTIVE, 1'b1, 16'hFFFF, 16'hFFFF);
    @(negedge clk_i);
    queue_traffic(100);
    drain();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dbcf_pkg.sv
sv/dbcf_if.sv
sv/dbcf_cfg.sv
sv/dbcf_core.sv
sv/dram_bank_command_fsm_unit.sv
bench/dram_bank_command_fsm_unit_tb.sv
